[design/mas_pkg.sv]
package mas_pkg;

  localparam int unsigned SlotsDefault = 16;
  localparam int unsigned IdW = 31;
  localparam logic [IdW-1:0] IdMax = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    OpAdd    = 2'd0,
    OpCancel = 2'd1,
    OpTick   = 2'd2,
    OpDone   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StInvalid  = 3'd1,
    StPassed   = 3'd2,
    StFull     = 3'd3,
    StNotFound = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    FsmIdle,
    FsmIdScan,
    FsmApply,
    FsmSelScan,
    FsmArmScan,
    FsmOut
  } fsm_e;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic rotate;     // shift the ring by one cell
    logic write_new;  // load head cell with a new alarm
    logic clr_active; // head cell: clear active
    logic free_head;  // head cell: free entirely
    logic reload;     // head cell: clear firing, set deadline
    logic set_firing; // head cell: set firing
  } cell_ctrl_t;

  // Head cell contents seen by the sequencer
  typedef struct packed {
    logic            active;
    logic            firing;
    logic [IdW-1:0]  ident;
    logic [63:0]     deadline;
    logic [31:0]     tag;
  } cell_view_t;

endpackage

[design/mas_cell.sv]
module mas_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mas_pkg::cell_ctrl_t ctrl_i,
  input  logic                head_i,
  input  mas_pkg::cell_view_t new_i,
  input  mas_pkg::cell_view_t prev_i,
  output mas_pkg::cell_view_t cell_o
);
  import mas_pkg::*;

  cell_view_t cell_d, cell_q;

  // Rotation takes the neighbour's word; edits act on the head cell only
  always_comb begin
    cell_d = cell_q;
    if (head_i) begin
      if (ctrl_i.write_new) cell_d = new_i;
      if (ctrl_i.clr_active) cell_d.active = 1'b0;
      if (ctrl_i.free_head) cell_d = '0;
      if (ctrl_i.reload) begin
        cell_d.firing   = 1'b0;
        cell_d.deadline = new_i.deadline;
      end
      if (ctrl_i.set_firing) cell_d.firing = 1'b1;
    end
    if (ctrl_i.rotate) cell_d = prev_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

[design/mas_ring.sv]
module mas_ring #(
  parameter int unsigned Slots = mas_pkg::SlotsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mas_pkg::cell_ctrl_t ctrl_i,
  input  mas_pkg::cell_view_t new_i,
  output mas_pkg::cell_view_t head_o
);
  import mas_pkg::*;

  cell_view_t cells [Slots];

  // Ring of cells: cell i takes from cell i+1, the last from the head
  for (genvar i = 0; i < Slots; i++) begin : g_cell
    mas_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl_i),
      .head_i (i == 0),
      .new_i  (new_i),
      .prev_i (cells[(i + 1) % Slots]),
      .cell_o (cells[i])
    );
  end

  assign head_o = cells[0];

endmodule

[design/multi_alarm_scheduler.sv]
// Alarm pool of Slots entries held in a ring of cells that rotates one place a
// cycle past a single head cell. A word runs an apply pass, two selection passes
// (find the earliest expired alarm, then mark it) and a compare pass. Each pass is
// one full turn of the ring. An output state then loads the result. The ring holds
// still while the head cell is edited, and there are at most two edits. An add
// with a valid tag and delay first scans the ring once per id it tries, up to
// Slots + 1 ids. Results wait in an output register. The next word is taken only
// once the result has gone.
module multi_alarm_scheduler #(
  parameter int unsigned Slots = mas_pkg::SlotsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            operation_i,
  input  logic [63:0]           now_us_i,
  input  logic [31:0]           delay_us_i,
  input  logic                  fire_if_past_i,
  input  logic [31:0]           handler_tag_i,
  input  logic [mas_pkg::IdW-1:0] alarm_id_i,
  input  logic signed [63:0]    reload_delay_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            status_o,
  output logic [mas_pkg::IdW-1:0] new_id_o,
  output logic                  fired_o,
  output logic [mas_pkg::IdW-1:0] fired_id_o,
  output logic [31:0]           fired_tag_o,
  output logic                  armed_o,
  output logic [63:0]           compare_value_o
);
  import mas_pkg::*;

  localparam int unsigned CntW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned TryW = $clog2(Slots + 2);
  localparam logic [CntW-1:0] LastCnt = CntW'(Slots - 1);
  localparam logic [TryW-1:0] LastTry = TryW'(Slots);

  fsm_e state_q, state_d;
  cell_ctrl_t ctrl;
  cell_view_t head, new_cell;

  // Latched input word
  op_e            op_q;
  logic [63:0]    now_q;
  logic [31:0]    delay_q;
  logic [31:0]    tag_q;
  logic [IdW-1:0] aid_q;
  logic [63:0]    reload_q;

  logic [CntW-1:0] cnt_q;
  logic [TryW-1:0] try_q;
  logic [IdW-1:0]  next_id_q, cand_q;
  logic [IdW-1:0]  id_save_q;  // id counter before the search, kept if the pool is full
  logic            busy_q;     // candidate id found in scan
  logic            done_q;     // head edit taken this pass (apply or mark)
  logic            firing_q;   // some slot firing (after apply)
  logic            sel_v_q;
  logic [63:0]     sel_dl_q;
  logic [CntW-1:0] sel_pos_q;
  logic            sel_take_q; // second selection pass marks winner
  logic            arm_q;
  logic [63:0]     best_q;
  logic [2:0]      status_q;
  logic [IdW-1:0]  nid_q, fid_q;
  logic            fired_q;
  logic [31:0]     ftag_q;
  logic            ov_q;

  logic last;
  logic head_busy;
  logic head_live;
  logic head_elig;
  logic positive;
  logic sel_ok;
  logic [IdW-1:0] cand_next;

  assign last      = (cnt_q == LastCnt);
  assign head_live = head.active | head.firing;
  assign head_busy = head_live && head.ident == cand_q;
  assign head_elig = head.active && !head.firing && head.deadline <= now_q;
  assign positive  = !reload_q[63] && reload_q != '0;
  assign sel_ok    = (op_q == OpTick || op_q == OpDone) && !firing_q;
  assign cand_next = (next_id_q == '0) ? IdW'(1) : next_id_q;

  mas_ring #(.Slots(Slots)) u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .new_i  (new_cell),
    .head_o (head)
  );

  assign in_stall_o = (state_q != FsmIdle) || ov_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FsmIdle:    if (in_valid_i && !ov_q) begin
        state_d = FsmApply;
        if (operation_i == OpAdd && handler_tag_i != '0 &&
            !(delay_us_i == '0 && !fire_if_past_i)) state_d = FsmIdScan;
      end
      FsmIdScan:  if (last && (!(busy_q || head_busy) || try_q == LastTry))
                    state_d = FsmApply;
      FsmApply:   if (last && ctrl.rotate) state_d = FsmSelScan;
      FsmSelScan: if (last && sel_take_q && ctrl.rotate) state_d = FsmArmScan;
      FsmArmScan: if (last) state_d = FsmOut;
      FsmOut:     state_d = FsmIdle;
      default:    state_d = FsmIdle;
    endcase
  end

  // Ring control
  always_comb begin
    ctrl = '0;
    new_cell = '0;
    new_cell.active   = 1'b1;
    new_cell.ident    = cand_q;
    new_cell.deadline = now_q + ((delay_q == '0) ? 64'd1 : {32'd0, delay_q});
    new_cell.tag      = tag_q;
    unique case (state_q)
      FsmIdScan, FsmArmScan: ctrl.rotate = 1'b1;
      FsmApply: begin
        ctrl.rotate = 1'b1;
        if (!done_q) begin
          unique case (op_q)
            OpAdd: if (status_q == StFull && !head_live) begin
              ctrl.write_new = 1'b1;
              ctrl.rotate = 1'b0;
            end
            OpCancel: if (status_q == StNotFound && head.active && head.ident == aid_q) begin
              ctrl.rotate = 1'b0;
              if (head.firing) ctrl.clr_active = 1'b1;
              else ctrl.free_head = 1'b1;
            end
            OpDone: if (head.firing) begin
              ctrl.rotate = 1'b0;
              if (head.active && positive) begin
                ctrl.reload = 1'b1;
                new_cell.deadline = now_q + reload_q;
              end else begin
                ctrl.free_head = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      FsmSelScan: begin
        ctrl.rotate = 1'b1;
        if (sel_take_q && sel_v_q && cnt_q == sel_pos_q && !done_q) begin
          ctrl.set_firing = 1'b1;
          ctrl.rotate = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FsmIdle;
      cnt_q <= '0;
      try_q <= '0;
      next_id_q <= IdW'(1);
      ov_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      if (ctrl.rotate) cnt_q <= last ? '0 : cnt_q + CntW'(1);
      unique case (state_q)
        FsmIdle: if (state_d != FsmIdle) begin
          cnt_q <= '0;
          try_q <= '0;
          done_q <= 1'b0;
          if (state_d == FsmIdScan) begin
            cand_q <= cand_next;
            next_id_q <= (cand_next >= IdMax) ? IdW'(1) : cand_next + IdW'(1);
          end
        end
        FsmIdScan: if (last && (busy_q || head_busy) && try_q != LastTry) begin
          try_q <= try_q + TryW'(1);
          cand_q <= cand_next;
          next_id_q <= (cand_next >= IdMax) ? IdW'(1) : cand_next + IdW'(1);
        end
        FsmApply: begin
          if (ctrl.rotate && last) done_q <= 1'b0;
          else if (!ctrl.rotate) done_q <= 1'b1;
          // no free slot: the id counter is left as it was
          if (ctrl.rotate && last && op_q == OpAdd && status_q == StFull)
            next_id_q <= id_save_q;
        end
        FsmSelScan: begin
          if (ctrl.set_firing) done_q <= 1'b1;
        end
        FsmOut: ov_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath registers (no reset needed)
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      FsmIdle: if (in_valid_i && !ov_q) begin
        op_q     <= op_e'(operation_i);
        now_q    <= now_us_i;
        delay_q  <= delay_us_i;
        tag_q    <= handler_tag_i;
        aid_q    <= alarm_id_i;
        reload_q <= reload_delay_i;
        id_save_q <= next_id_q;
        busy_q   <= 1'b0;
        firing_q <= 1'b0;
        sel_v_q  <= 1'b0;
        sel_take_q <= 1'b0;
        arm_q    <= 1'b0;
        fired_q  <= 1'b0;
        fid_q    <= '0;
        ftag_q   <= '0;
        nid_q    <= '0;
        // Cancel of a nonzero id starts as not found until a hit is seen
        status_q <= StOk;
        if (operation_i == OpAdd) begin
          if (handler_tag_i == '0) status_q <= StInvalid;
          else if (delay_us_i == '0 && !fire_if_past_i) status_q <= StPassed;
          else status_q <= StFull;
        end else if (operation_i == OpCancel) begin
          status_q <= (alarm_id_i == '0) ? StInvalid : StNotFound;
        end
      end
      FsmIdScan: begin
        busy_q <= last ? 1'b0 : (busy_q | head_busy);
      end
      FsmApply: begin
        if (op_q == OpCancel && status_q == StNotFound && head.active &&
            head.ident == aid_q && !done_q) status_q <= StOk;
        if (ctrl.write_new) begin
          nid_q <= cand_q;
          status_q <= StOk;
        end
        if (ctrl.rotate && head.firing) firing_q <= 1'b1;
      end
      FsmSelScan: begin
        if (sel_ok && !sel_take_q && head_elig &&
            (!sel_v_q || head.deadline < sel_dl_q)) begin
          sel_v_q <= 1'b1;
          sel_dl_q <= head.deadline;
          sel_pos_q <= cnt_q;
        end
        if (last) sel_take_q <= 1'b1;
        if (ctrl.set_firing) begin
          fired_q <= 1'b1;
          fid_q <= head.ident;
          ftag_q <= head.tag;
        end
      end
      FsmArmScan: if (head.active && !head.firing) begin
        if (!arm_q || head.deadline < best_q) best_q <= head.deadline;
        arm_q <= 1'b1;
      end
      default: ;
    endcase
  end

  // Result register
  assign out_valid_o     = ov_q;
  assign status_o        = status_q;
  assign new_id_o        = nid_q;
  assign fired_o         = fired_q;
  assign fired_id_o      = fid_q;
  assign fired_tag_o     = ftag_q;
  assign armed_o         = arm_q;
  assign compare_value_o = !arm_q ? 64'd0 : (best_q > now_q) ? best_q : now_q + 64'd1;

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != FsmIdle) |-> in_stall_o) else $error("accepting while busy");
  a_fired_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fired_o) |-> (fired_id_o != '0)) else $error("fired with zero id");
  a_newid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && new_id_o != '0) |-> (status_o == StOk)) else $error("id on failure");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");

endmodule
